FILE: sv/hmf_pkg.sv
// ----------------------------------------------------------------------------
// hmf_pkg: shared types and constants of the histogram median filter
// Operation requests between the front and back, register map, bin layout.
// ----------------------------------------------------------------------------
package hmf_pkg;

    localparam int DEF_MAX_RADIUS = 8;
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W  = 8;
    localparam int BINS   = 256;
    localparam int GRP_W  = 4;            // coarse group index, upper value bits
    localparam int FINE_W = PIX_W - GRP_W;
    localparam int GROUPS = BINS >> FINE_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register map (index = paddr[3:2])
    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    localparam logic [3:0]  RST_RADIUS = 4'd8;
    localparam logic [8:0]  RST_WIDTH  = 9'd320;
    localparam logic [10:0] RST_HEIGHT = 11'd240;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,   // row start: empty the histogram
        OP_ADDREM = 2'd1,   // add one pixel, optionally drop an old one
        OP_MEDIAN = 2'd2    // search and emit
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [PIX_W-1:0]   add_val;
        logic [PIX_W-1:0]   rem_val;
        logic               rem_en;
        logic               eol;
        logic               eof;
    } hmf_op_t;

endpackage

FILE: sv/histogram_median_filter.sv
// ----------------------------------------------------------------------------
// histogram_median_filter: square-window median filter on a padded grey frame
// APB register block, front (line stores), request queue, back (histogram).
// ----------------------------------------------------------------------------
// Feed the padded frame (radius pixels of border on every side) in raster
// order; one median comes out for every active pixel, with tlast on the last
// pixel of a row and tuser on the last pixel of the frame. Pixels of the top
// border rows only fill the line stores. For an active pixel the front does
// one line-store read and pushes one add request per window row; the back,
// which sets the sustained rate, pops each request and does one histogram
// read-modify-write for an added entry and a second one for a swapped entry
// once the window slides. The median search pops its request, walks up to
// 16 coarse groups, reads the bins of one group and then emits. Any write to
// the radius, width or height register restarts the frame at its first
// padded pixel.
// ----------------------------------------------------------------------------
module histogram_median_filter #(
    parameter int MAX_RADIUS = hmf_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = hmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hmf_pkg::DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // median_value
    output logic        m_tlast,   // end_of_line
    output logic [0:0]  m_tuser    // end_of_frame
);
    import hmf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT + 2*MAX_RADIUS);
    localparam int TR_W  = $clog2(MAX_RADIUS+1) + 1;
    localparam int CNT_W = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1);
    localparam int R_LIM = (MAX_RADIUS < (MAX_WIDTH-1)/2) ? MAX_RADIUS : (MAX_WIDTH-1)/2;

    logic [3:0]        radius_reg;
    logic [8:0]        width_reg;
    logic [10:0]       height_reg;
    logic              cfg_we;
    logic              restart;
    logic [TR_W-1:0]   two_r;
    logic [CW:0]       pw;
    logic [RW-1:0]     ph;
    logic [CNT_W-1:0]  half;

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    hmf_op_t           q_wdata;
    hmf_op_t           q_rdata;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign restart = cfg_we && ((paddr[3:2] == REG_RADIUS) || (paddr[3:2] == REG_WIDTH)
                                || (paddr[3:2] == REG_HEIGHT));

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RADIUS: prdata = {28'd0, radius_reg};
            REG_WIDTH:  prdata = {23'd0, width_reg};
            REG_HEIGHT: prdata = {21'd0, height_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RST_RADIUS;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_RADIUS: radius_reg <= pwdata[3:0];
                REG_WIDTH:  width_reg  <= pwdata[8:0];
                REG_HEIGHT: height_reg <= pwdata[10:0];
                default:    radius_reg <= radius_reg;
            endcase
        end
    end

    // clamp the registers into the supported frame geometry
    always_comb
    begin
        int r;
        int w;
        int h;
        int wl;
        r = int'(radius_reg);
        if (r < 1) r = 1;
        if (r > R_LIM) r = R_LIM;
        wl = MAX_WIDTH - 2*r;
        w = int'(width_reg);
        if (w < 1) w = 1;
        if (w > wl) w = wl;
        h = int'(height_reg);
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        two_r = TR_W'(2*r);
        pw    = (CW+1)'(w + 2*r);
        ph    = RW'(h + 2*r);
        half  = CNT_W'(((2*r+1) * (2*r+1)) >> 1);
    end

    hmf_front #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .restart  (restart),
        .two_r    (two_r),
        .pw       (pw),
        .ph       (ph),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    hmf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    hmf_back #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .half     (half),
        .q_empty  (q_empty),
        .q_data   (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_empty))
        else $error("request popped from an empty queue");

    a_restart_ready: assert property (@(posedge clk) disable iff (!rst_n)
        restart |=> s_tready)
        else $error("front not ready after a frame restart");

endmodule

FILE: sv/hmf_queue.sv
// ----------------------------------------------------------------------------
// hmf_queue: request queue between front and back
// Small register FIFO so the front and back stall independently.
// ----------------------------------------------------------------------------
module hmf_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hmf_pkg::hmf_op_t wdata,
    output logic             full,
    input  logic             pop,
    output hmf_pkg::hmf_op_t rdata,
    output logic             empty
);
    import hmf_pkg::*;

    hmf_op_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QPTR_W:0]     cnt_reg, cnt_next;

    assign full  = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign rdata = mem[rptr_reg];

    always_comb
    begin
        wptr_next = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: sv/hmf_front.sv
// ----------------------------------------------------------------------------
// hmf_front: pixel intake, line stores and column ring
// Tracks the padded position, keeps 2r line stores and the last 2r+1 window
// columns, and issues histogram requests for every active pixel.
// ----------------------------------------------------------------------------
module hmf_front #(
    parameter int MAX_RADIUS = hmf_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = hmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hmf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        restart,
    input  logic [$clog2(MAX_RADIUS+1):0]               two_r,
    input  logic [$clog2(MAX_WIDTH):0]                  pw,
    input  logic [$clog2(MAX_HEIGHT+2*MAX_RADIUS)-1:0]  ph,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [7:0]                                  s_tdata,   // pixel
    input  logic                                        q_full,
    output logic                                        q_push,
    output hmf_pkg::hmf_op_t                            q_data
);
    import hmf_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT + 2*MAX_RADIUS);
    localparam int SIDE_W = $clog2(2*MAX_RADIUS + 2);
    localparam int SLOT_W = $clog2(2*MAX_RADIUS) > 0 ? $clog2(2*MAX_RADIUS) : 1;
    localparam int TR_W   = $clog2(MAX_RADIUS+1) + 1;
    localparam int LS_AW  = SLOT_W + CW;
    localparam int CM_AW  = 2 * SIDE_W;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_CLR  = 5'b00010,
        F_READ = 5'b00100,
        F_PUSH = 5'b01000,
        F_MED  = 5'b10000
    } front_state_t;

    front_state_t       state_reg, state_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [SLOT_W-1:0]  base_reg, base_next;     // slot of the current row
    logic [SIDE_W-1:0]  cslot_reg, cslot_next;   // column ring slot
    logic [SIDE_W-1:0]  k_reg, k_next;           // row within the window column
    logic [SLOT_W-1:0]  kslot_reg, kslot_next;
    logic [PIX_W-1:0]   px_reg;

    logic [PIX_W-1:0]   ls_mem [(2*MAX_RADIUS) << CW];
    logic [PIX_W-1:0]   cm_mem [1 << CM_AW];
    logic [PIX_W-1:0]   ls_rdata_reg;
    logic [PIX_W-1:0]   cm_rdata_reg;

    logic               ls_we;
    logic [PIX_W-1:0]   ls_wdata;
    logic               cm_we;
    logic [LS_AW-1:0]   ls_waddr;
    logic [LS_AW-1:0]   ls_raddr;
    logic [CM_AW-1:0]   cm_addr;
    logic [PIX_W-1:0]   add_val;
    logic               advance;
    logic               in_active;
    logic               k_last;
    logic               col_ge_side;
    logic               col_ge_2r;
    logic               eol;
    logic               eof;
    logic [SLOT_W-1:0]  slot_top;

    assign s_tready    = (state_reg == F_IDLE);
    assign in_active   = (32'(row_reg) >= 32'(two_r));
    assign k_last      = (32'(k_reg) == 32'(two_r));
    assign col_ge_side = (32'(col_reg) > 32'(two_r));
    assign col_ge_2r   = (32'(col_reg) >= 32'(two_r));
    assign eol         = ({1'b0, col_reg} == pw - (CW+1)'(1));
    assign eof         = eol && (row_reg == ph - RW'(1));
    assign slot_top    = SLOT_W'(two_r - TR_W'(1));
    assign ls_waddr    = {base_reg, col_reg};
    assign ls_raddr    = {kslot_reg, col_reg};
    assign cm_addr     = {cslot_reg, k_reg};
    assign add_val     = k_last ? px_reg : ls_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ls_we)
        begin
            ls_mem[ls_waddr] <= ls_wdata;
        end
        ls_rdata_reg <= ls_mem[ls_raddr];
        if (cm_we)
        begin
            cm_mem[cm_addr] <= add_val;
        end
        cm_rdata_reg <= cm_mem[cm_addr];
        if (s_tvalid && s_tready)
        begin
            px_reg <= s_tdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        base_next  = base_reg;
        cslot_next = cslot_reg;
        k_next     = k_reg;
        kslot_next = kslot_reg;
        q_push     = 1'b0;
        q_data     = '0;
        ls_we      = 1'b0;
        ls_wdata   = px_reg;
        cm_we      = 1'b0;
        advance    = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_active)
                    begin
                        k_next     = '0;
                        kslot_next = base_reg;
                        state_next = (col_reg == '0) ? F_CLR : F_READ;
                    end
                    else
                    begin
                        // top border rows only fill the line stores
                        ls_we    = 1'b1;
                        ls_wdata = s_tdata;
                        advance  = 1'b1;
                    end
                end
            end
            F_CLR:
            begin
                if (!q_full)
                begin
                    q_push      = 1'b1;
                    q_data.kind = OP_CLEAR;
                    state_next  = F_READ;
                end
            end
            F_READ:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push         = 1'b1;
                    q_data.kind    = OP_ADDREM;
                    q_data.add_val = add_val;
                    q_data.rem_val = cm_rdata_reg;
                    q_data.rem_en  = col_ge_side;
                    cm_we          = 1'b1;
                    if (k_last)
                    begin
                        // slot of row-2r is consumed now, overwrite with this row
                        ls_we = 1'b1;
                        if (col_ge_2r)
                        begin
                            state_next = F_MED;
                        end
                        else
                        begin
                            advance    = 1'b1;
                            state_next = F_IDLE;
                        end
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        kslot_next = (kslot_reg == slot_top) ? '0 : kslot_reg + 1'b1;
                        state_next = F_READ;
                    end
                end
            end
            F_MED:
            begin
                if (!q_full)
                begin
                    q_push      = 1'b1;
                    q_data.kind = OP_MEDIAN;
                    q_data.eol  = eol;
                    q_data.eof  = eof;
                    advance     = 1'b1;
                    state_next  = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        if (advance)
        begin
            if (eol)
            begin
                col_next   = '0;
                cslot_next = '0;
                if (eof)
                begin
                    row_next  = '0;
                    base_next = '0;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    base_next = (base_reg == slot_top) ? '0 : base_reg + 1'b1;
                end
            end
            else
            begin
                col_next   = col_reg + 1'b1;
                cslot_next = (32'(cslot_reg) == 32'(two_r)) ? '0 : cslot_reg + 1'b1;
            end
        end

        if (restart)
        begin
            state_next = F_IDLE;
            col_next   = '0;
            row_next   = '0;
            base_next  = '0;
            cslot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            base_reg  <= '0;
            cslot_reg <= '0;
            k_reg     <= '0;
            kslot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            base_reg  <= base_next;
            cslot_reg <= cslot_next;
            k_reg     <= k_next;
            kslot_reg <= kslot_next;
        end
    end

endmodule

FILE: sv/hmf_back.sv
// ----------------------------------------------------------------------------
// hmf_back: histogram and median search
// 256-bin histogram in a memory with per-bin valid bits, 16 coarse group
// counts in flops; the search walks the groups, then the bins of one group.
// ----------------------------------------------------------------------------
module hmf_back #(
    parameter int MAX_RADIUS = hmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                                                       clk,
    input  logic                                                       rst_n,
    input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0]     half,
    input  logic                                                       q_empty,
    input  hmf_pkg::hmf_op_t                                           q_data,
    output logic                                                       q_pop,
    output logic                                                       m_tvalid,
    input  logic                                                       m_tready,
    output logic [7:0]                                                 m_tdata,  // median_value
    output logic                                                       m_tlast,  // end_of_line
    output logic [0:0]                                                 m_tuser   // end_of_frame
);
    import hmf_pkg::*;

    localparam int CNT_W = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1);

    typedef enum logic [8:0] {
        B_IDLE  = 9'b000000001,
        B_ARD   = 9'b000000010,
        B_AWR   = 9'b000000100,
        B_RRD   = 9'b000001000,
        B_RWR   = 9'b000010000,
        B_CSCAN = 9'b000100000,
        B_FRD   = 9'b001000000,
        B_FCHK  = 9'b010000000,
        B_EMIT  = 9'b100000000
    } back_state_t;

    back_state_t        state_reg, state_next;
    hmf_op_t            op_reg;
    logic [CNT_W-1:0]   acc_reg, acc_next;
    logic [GRP_W-1:0]   grp_reg, grp_next;
    logic [FINE_W-1:0]  fine_reg, fine_next;
    logic [BINS-1:0]    hv_reg;
    logic [CNT_W-1:0]   coarse_reg [GROUPS];
    logic [CNT_W-1:0]   hist_mem [BINS];
    logic [CNT_W-1:0]   hist_rdata_reg;
    logic               hv_rd_reg;
    logic               out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]   out_data_reg;
    logic               out_eol_reg;
    logic               out_eof_reg;

    logic [PIX_W-1:0]   hist_raddr;
    logic [PIX_W-1:0]   hist_waddr;
    logic [CNT_W-1:0]   hist_wdata;
    logic               hist_we;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   sum;
    logic               clr;
    logic               load;

    assign cnt      = hv_rd_reg ? hist_rdata_reg : '0;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_eol_reg;
    assign m_tuser  = out_eof_reg;

    always_comb
    begin
        priority case (1'b1)
            state_reg == B_ARD: hist_raddr = op_reg.add_val;
            state_reg == B_RRD: hist_raddr = op_reg.rem_val;
            default:            hist_raddr = {grp_reg, fine_reg};
        endcase
        hist_waddr = (state_reg == B_RWR) ? op_reg.rem_val : op_reg.add_val;
        hist_wdata = (state_reg == B_RWR) ? cnt - CNT_W'(1) : cnt + CNT_W'(1);
        hist_we    = (state_reg == B_AWR) || (state_reg == B_RWR);
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_rdata_reg <= hist_mem[hist_raddr];
        hv_rd_reg      <= hv_reg[hist_raddr];
        if (q_pop)
        begin
            op_reg <= q_data;
        end
        if (load)
        begin
            out_data_reg <= {grp_reg, fine_reg};
            out_eol_reg  <= op_reg.eol;
            out_eof_reg  <= op_reg.eof;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        grp_next   = grp_reg;
        fine_next  = fine_reg;
        q_pop      = 1'b0;
        clr        = 1'b0;
        load       = 1'b0;
        sum        = acc_reg + cnt;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_data.kind)
                        OP_CLEAR:  clr = 1'b1;
                        OP_ADDREM: state_next = B_ARD;
                        OP_MEDIAN:
                        begin
                            acc_next   = '0;
                            grp_next   = '0;
                            state_next = B_CSCAN;
                        end
                        default:   clr = 1'b0;
                    endcase
                end
            end
            B_ARD:   state_next = B_AWR;
            B_AWR:   state_next = op_reg.rem_en ? B_RRD : B_IDLE;
            B_RRD:   state_next = B_RWR;
            B_RWR:   state_next = B_IDLE;
            B_CSCAN:
            begin
                sum = acc_reg + coarse_reg[grp_reg];
                if (sum > half)
                begin
                    fine_next  = '0;
                    state_next = B_FRD;
                end
                else
                begin
                    acc_next = sum;
                    grp_next = grp_reg + 1'b1;
                end
            end
            B_FRD:   state_next = B_FCHK;
            B_FCHK:
            begin
                if (sum > half)
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    acc_next   = sum;
                    fine_next  = fine_reg + 1'b1;
                    state_next = B_FRD;
                end
            end
            B_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            acc_reg       <= '0;
            grp_reg       <= '0;
            fine_reg      <= '0;
            hv_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < GROUPS; i++)
            begin
                coarse_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            grp_reg       <= grp_next;
            fine_reg      <= fine_next;
            out_valid_reg <= out_valid_next;
            if (clr)
            begin
                hv_reg <= '0;
                for (int i = 0; i < GROUPS; i++)
                begin
                    coarse_reg[i] <= '0;
                end
            end
            else if (state_reg == B_AWR)
            begin
                hv_reg[op_reg.add_val] <= 1'b1;
                coarse_reg[op_reg.add_val[PIX_W-1:FINE_W]] <=
                    coarse_reg[op_reg.add_val[PIX_W-1:FINE_W]] + CNT_W'(1);
            end
            else if (state_reg == B_RWR)
            begin
                coarse_reg[op_reg.rem_val[PIX_W-1:FINE_W]] <=
                    coarse_reg[op_reg.rem_val[PIX_W-1:FINE_W]] - CNT_W'(1);
            end
        end
    end

endmodule
